>>> src/qxmix_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qxmix_pkg
// Shared types, codes and constants of the X-frame motor mixer core.
// ----------------------------------------------------------------------------
package qxmix_pkg;

    // field and datapath widths
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 4;
    localparam int DIV_W      = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    // operation codes
    localparam logic [1:0] OP_CONTROL = 2'd0;
    localparam logic [1:0] OP_ARM     = 2'd1;
    localparam logic [1:0] OP_START   = 2'd2;
    localparam logic [1:0] OP_THRUST  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARM    = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0] RST_MIN    = 16'd1000;
    localparam logic [CFG_W-1:0] RST_MAX    = 16'd2000;
    localparam logic [CFG_W-1:0] RST_RANGE  = 16'd1000;
    localparam logic [CFG_W-1:0] RST_PERIOD = 16'd2500;
    localparam logic [CFG_W-1:0] RST_ARM    = 16'd1000;

    localparam logic [6:0]       PCT_FULL   = 7'd100;
    localparam logic [CFG_W-1:0] FULL_SCALE = 16'hFFFF;

    // floor(x / 100) for x below 2**23 as (x * RECIP_100) >> RECIP_SH
    localparam int          RECIP_SH  = 30;
    localparam logic [23:0] RECIP_100 = 24'd10737419;

    // microprogram addresses
    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] ST_CU_PROD  = 4'd1;
    localparam logic [STEP_W-1:0] ST_CU_DIV   = 4'd2;
    localparam logic [STEP_W-1:0] ST_CU_BASE  = 4'd3;
    localparam logic [STEP_W-1:0] ST_CU_MIX   = 4'd4;
    localparam logic [STEP_W-1:0] ST_CU_SCALE = 4'd5;
    localparam logic [STEP_W-1:0] ST_CU_CDIV  = 4'd6;
    localparam logic [STEP_W-1:0] ST_CU_STORE = 4'd7;
    localparam logic [STEP_W-1:0] ST_FIN      = 4'd8;
    localparam logic [STEP_W-1:0] ST_ARM      = 4'd9;
    localparam logic [STEP_W-1:0] ST_SG_SCALE = 4'd10;
    localparam logic [STEP_W-1:0] ST_SG_DIV   = 4'd11;
    localparam logic [STEP_W-1:0] ST_SG_STORE = 4'd12;
    localparam logic [STEP_W-1:0] ST_START    = 4'd13;
    localparam logic [STEP_W-1:0] ST_THRUST   = 4'd14;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [11:0] pitch_offset;
        logic signed [11:0] roll_offset;
        logic signed [11:0] yaw_offset;
        logic [1:0]         motor_index;
        logic               arm_request;
        logic [7:0]         thrust_value;
    } t_in;

    typedef struct packed {
        logic [15:0] compare_one;
        logic [15:0] compare_two;
        logic [15:0] compare_three;
        logic [15:0] compare_four;
        logic [3:0]  armed_mask;
        logic [6:0]  thrust_percent;
        logic        rejected;
    } t_out;

    // datapath operations of one control word
    typedef enum logic [3:0] {
        DP_NOP,
        DP_PROD,
        DP_DIV,
        DP_BASE,
        DP_MIX,
        DP_SCALE,
        DP_STORE,
        DP_ARM,
        DP_LDMIN,
        DP_THRUST,
        DP_RECIP
    } t_dp_op;

    // sequencer branch kinds
    typedef enum logic [2:0] {
        BR_NEXT,
        BR_JUMP,
        BR_DIV,
        BR_MOTOR,
        BR_NOARM,
        BR_OUT,
        BR_DISPATCH
    } t_br;

    typedef struct packed {
        t_dp_op              dp;
        t_br                 br;
        logic [STEP_W-1:0]   target;
    } t_uword;

    typedef struct packed {
        t_dp_op dp;
        logic   capture;
        logic   out_load;
    } t_ctrl;

    typedef struct packed {
        logic div_last;
        logic motor_last;
        logic arm_req;
        logic out_busy;
    } t_stat;

    // X-frame signs as negate flags {pitch, roll, yaw}
    function automatic logic [2:0] mix_negs(input logic [1:0] m);
        logic [2:0] r;
        case (m)
            2'd0:    r = 3'b010;
            2'd1:    r = 3'b001;
            2'd2:    r = 3'b100;
            default: r = 3'b111;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/qxmix_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qxmix_seq
// Step counter and control-word ROM that run the mixer datapath.
// ----------------------------------------------------------------------------
module qxmix_seq import qxmix_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    input  t_stat      i_stat,
    output t_ctrl      o_ctrl,
    output logic       o_busy
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [STEP_W-1:0] step_inc;
    t_uword            uw;

    // microprogram
    function automatic t_uword urom(input logic [STEP_W-1:0] a);
        t_uword w;
        case (a)
            ST_IDLE:     w = '{DP_NOP,    BR_DISPATCH, ST_IDLE};
            ST_CU_PROD:  w = '{DP_PROD,   BR_NEXT,     ST_IDLE};
            ST_CU_DIV:   w = '{DP_RECIP,  BR_NEXT,     ST_IDLE};
            ST_CU_BASE:  w = '{DP_BASE,   BR_NEXT,     ST_IDLE};
            ST_CU_MIX:   w = '{DP_MIX,    BR_NEXT,     ST_IDLE};
            ST_CU_SCALE: w = '{DP_SCALE,  BR_NEXT,     ST_IDLE};
            ST_CU_CDIV:  w = '{DP_DIV,    BR_DIV,      ST_IDLE};
            ST_CU_STORE: w = '{DP_STORE,  BR_MOTOR,    ST_CU_MIX};
            ST_FIN:      w = '{DP_NOP,    BR_OUT,      ST_IDLE};
            ST_ARM:      w = '{DP_ARM,    BR_NOARM,    ST_FIN};
            ST_SG_SCALE: w = '{DP_SCALE,  BR_NEXT,     ST_IDLE};
            ST_SG_DIV:   w = '{DP_DIV,    BR_DIV,      ST_IDLE};
            ST_SG_STORE: w = '{DP_STORE,  BR_JUMP,     ST_FIN};
            ST_START:    w = '{DP_LDMIN,  BR_JUMP,     ST_SG_SCALE};
            ST_THRUST:   w = '{DP_THRUST, BR_JUMP,     ST_FIN};
            default:     w = '{DP_NOP,    BR_JUMP,     ST_IDLE};
        endcase
        return w;
    endfunction

    // entry point per operation
    function automatic logic [STEP_W-1:0] entry(input logic [1:0] op);
        logic [STEP_W-1:0] e;
        case (op)
            OP_CONTROL: e = ST_CU_PROD;
            OP_ARM:     e = ST_ARM;
            OP_START:   e = ST_START;
            default:    e = ST_THRUST;
        endcase
        return e;
    endfunction

    assign uw       = urom(r_step);
    assign step_inc = r_step + STEP_W'(1);

    // next step
    always_comb begin
        case (uw.br)
            BR_NEXT:     n_step = step_inc;
            BR_JUMP:     n_step = uw.target;
            BR_DIV:      n_step = i_stat.div_last ? step_inc : r_step;
            BR_MOTOR:    n_step = i_stat.motor_last ? step_inc : uw.target;
            BR_NOARM:    n_step = i_stat.arm_req ? step_inc : uw.target;
            BR_OUT:      n_step = i_stat.out_busy ? r_step : uw.target;
            BR_DISPATCH: n_step = i_in_valid ? entry(i_op) : r_step;
            default:     n_step = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ctrl.dp       = uw.dp;
        o_ctrl.capture  = (uw.br == BR_DISPATCH) && i_in_valid;
        o_ctrl.out_load = (uw.br == BR_OUT) && !i_stat.out_busy;
        o_busy          = (r_step != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

>>> src/qxmix_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qxmix_dp
// Mixer datapath: registers, mixer and clamp, shared serial divider, output.
// ----------------------------------------------------------------------------
module qxmix_dp import qxmix_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    output t_stat                o_stat,
    input  t_in                  i_in,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output t_out                 o_out
);

    // configuration
    logic [CFG_W-1:0] r_min, r_max, r_range, r_period, r_arm;

    // working registers
    t_in                  r_item;
    logic [DIV_W-1:0]     r_acc;
    logic [CFG_W-1:0]     r_rem;
    logic [CFG_W-1:0]     r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CFG_W:0]       r_base;
    logic [CFG_W-1:0]     r_on;
    logic [1:0]           r_motor;

    // visible state
    logic [CFG_W-1:0] r_cmp [4];
    logic [3:0]       r_armed;
    logic [6:0]       r_thrust;
    logic             r_out_valid;
    t_out             r_out;

    // mixer and clamp
    logic [2:0]         negs;
    logic signed [19:0] p_ext, r_ext, y_ext, mix_v, max_s, min_s;
    logic [CFG_W-1:0]   mix_on;

    // divider step and product
    logic [CFG_W:0]   rem_sh;
    logic [CFG_W:0]   rem_sub;
    logic             fits;
    logic [22:0]      prod;
    logic [46:0]      recip;
    logic [CFG_W-1:0] sat_cmp;
    logic             rej;

    always_comb begin
        negs  = mix_negs(r_motor);
        p_ext = 20'(r_item.pitch_offset);
        r_ext = 20'(r_item.roll_offset);
        y_ext = 20'(r_item.yaw_offset);
        mix_v = $signed({3'b000, r_base})
              + (negs[2] ? -p_ext : p_ext)
              + (negs[1] ? -r_ext : r_ext)
              + (negs[0] ? -y_ext : y_ext);
        max_s = $signed({4'b0000, r_max});
        min_s = $signed({4'b0000, r_min});
        if (mix_v > max_s) begin
            mix_on = r_max;
        end else if (mix_v < min_s) begin
            mix_on = r_min;
        end else begin
            mix_on = mix_v[CFG_W-1:0];
        end
    end

    // restoring division, one quotient bit per step; thrust scaling by
    // reciprocal multiply
    always_comb begin
        rem_sh  = {r_rem, r_acc[DIV_W-1]};
        fits    = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
        prod    = r_thrust * r_range;
        recip   = r_acc[22:0] * RECIP_100;
        sat_cmp = (|r_acc[DIV_W-1:CFG_W]) ? FULL_SCALE : r_acc[CFG_W-1:0];
        rej     = (r_item.operation == OP_THRUST) && (r_item.thrust_value > {1'b0, PCT_FULL});
    end

    always_comb begin
        o_stat.div_last   = (r_cnt == DIV_CNT_W'(DIV_W - 1));
        o_stat.motor_last = (r_motor == 2'd3);
        o_stat.arm_req    = r_item.arm_request;
        o_stat.out_busy   = r_out_valid && i_out_stall;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= RST_MIN;
            r_max    <= RST_MAX;
            r_range  <= RST_RANGE;
            r_period <= RST_PERIOD;
            r_arm    <= RST_ARM;
        end else if (i_cfg_valid && i_cfg_ready) begin
            case (i_cfg_index)
                REG_MIN:    r_min    <= i_cfg_data;
                REG_MAX:    r_max    <= i_cfg_data;
                REG_RANGE:  r_range  <= i_cfg_data;
                REG_PERIOD: r_period <= i_cfg_data;
                REG_ARM:    r_arm    <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_item  <= i_in;
            r_motor <= i_in.motor_index;
        end
        case (i_ctrl.dp)
            DP_PROD:  r_acc <= DIV_W'(prod);
            DP_RECIP: r_acc <= DIV_W'(recip[46:RECIP_SH]);
            DP_DIV: begin
                r_acc <= {r_acc[DIV_W-2:0], fits};
                r_rem <= fits ? rem_sub[CFG_W-1:0] : rem_sh[CFG_W-1:0];
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
            DP_BASE: begin
                r_base  <= {1'b0, r_min} + {1'b0, r_acc[CFG_W-1:0]};
                r_motor <= 2'd0;
            end
            DP_MIX:   r_on <= mix_on;
            DP_SCALE: begin
                r_acc <= {r_on, {CFG_W{1'b0}}} - {{CFG_W{1'b0}}, r_on};
                r_div <= r_period;
                r_rem <= '0;
                r_cnt <= '0;
            end
            DP_STORE: r_motor <= r_motor + 2'd1;
            DP_ARM: begin
                if (r_item.arm_request) begin
                    r_on <= r_arm;
                end
            end
            DP_LDMIN: r_on <= r_min;
            default:  ;
        endcase
    end

    // visible state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp       <= '{default: '0};
            r_armed     <= '0;
            r_thrust    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_ctrl.dp)
                DP_STORE: r_cmp[r_motor] <= sat_cmp;
                DP_ARM:   r_armed[r_motor] <= r_item.arm_request;
                DP_THRUST: begin
                    if (!rej) begin
                        r_thrust <= r_item.thrust_value[6:0];
                    end
                end
                default: ;
            endcase
            if (i_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_out.compare_one    <= r_cmp[0];
            r_out.compare_two    <= r_cmp[1];
            r_out.compare_three  <= r_cmp[2];
            r_out.compare_four   <= r_cmp[3];
            r_out.armed_mask     <= r_armed;
            r_out.thrust_percent <= r_thrust;
            r_out.rejected       <= rej;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

>>> src/quad_x_motor_mixer_pwm_core.sv
// Sequencing: a control update runs the 32-step serial divider for the compare
//   value once per motor; arm and startup run it once, disarm and set thrust
//   not at all; thrust scaling is one reciprocal multiply. The next transfer
//   is taken once the result is loaded into the result register.
// Reset: synchronous active low; registers return to their defaults, compare
//   values, armed mask and thrust clear at once, no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_pwm_core
// Four-motor X-frame mixer producing PWM compare values, microcoded control.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_pwm_core import qxmix_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_ctrl ctrl;
    t_stat stat;
    logic  busy;

    // registers take a write any cycle
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = busy;

    qxmix_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in.operation),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_busy     (busy)
    );

    qxmix_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

>>> src/qxmix_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qxmix_chk
// Port-level checks of the mixer core, bound to the top level.
// ----------------------------------------------------------------------------
module qxmix_chk import qxmix_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out                 o_out
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one item at a time: input closes right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after a transfer");

    // stored thrust never exceeds full scale
    a_thrust_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.thrust_percent <= PCT_FULL)
        else $error("thrust above full scale");

endmodule

bind quad_x_motor_mixer_pwm_core qxmix_chk u_chk (.*);
`default_nettype wire

>>> verif/qxmix_result_checker.sv
// ----------------------------------------------------------------------------
// qxmix_result_checker
// Watches the command, result and register channels of the X-frame mixer,
// keeps its own copy of the motor state and limits, and compares every
// result transfer with the oldest predicted result.
// ----------------------------------------------------------------------------
module qxmix_result_checker import qxmix_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in                  i_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out                 i_out,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_pending,
    output int                   o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // limit registers as the block should hold them
    logic [CFG_W-1:0] lim_min;
    logic [CFG_W-1:0] lim_max;
    logic [CFG_W-1:0] span;
    logic [CFG_W-1:0] period;
    logic [CFG_W-1:0] arm_us;

    // motor state
    logic [15:0] on_us   [4];
    logic [15:0] cmp_val [4];
    logic [3:0]  arm_bits;
    logic [6:0]  thrust_pct;

    t_out predicted_q[$];
    int   fails = 0;

    // compare value for an on-time, saturating; zero period means full scale
    function automatic logic [15:0] pwm_compare(input logic [15:0] on);
        logic [63:0] q;
        if (period == '0)
            return FULL_SCALE;
        q = (64'(FULL_SCALE) * 64'(on)) / 64'(period);
        return (q > 64'(FULL_SCALE)) ? FULL_SCALE : q[15:0];
    endfunction

    // X-frame signs: m1 +p -r +y, m2 +p +r -y, m3 -p +r +y, m4 -p -r -y
    function automatic int mixed_on_time(input int base, input int m,
                                         input int p, input int r, input int y);
        case (m)
            0:       return base + p - r + y;
            1:       return base + p + r - y;
            2:       return base - p + r + y;
            default: return base - p - r - y;
        endcase
    endfunction

    task automatic load_motor(input logic [1:0] m, input logic [15:0] on);
        on_us[m]   = on;
        cmp_val[m] = pwm_compare(on);
    endtask

    // apply one command to the local state and form the result it gives
    task automatic mix_command(input t_in cmd, output t_out res);
        int   base;
        int   v;
        logic rej;
        rej = 1'b0;
        case (cmd.operation)
            OP_CONTROL: begin
                base = int'(lim_min) +
                       int'((32'(thrust_pct) * 32'(span)) / 32'(PCT_FULL));
                for (int m = 0; m < 4; m++) begin
                    v = mixed_on_time(base, m, $signed(cmd.pitch_offset),
                                      $signed(cmd.roll_offset),
                                      $signed(cmd.yaw_offset));
                    // upper bound wins when the window is inverted
                    if (v > int'(lim_max))
                        v = int'(lim_max);
                    else if (v < int'(lim_min))
                        v = int'(lim_min);
                    load_motor(2'(m), v[15:0]);
                end
            end
            OP_ARM: begin
                if (cmd.arm_request) begin
                    load_motor(cmd.motor_index, arm_us);
                    arm_bits[cmd.motor_index] = 1'b1;
                end else begin
                    arm_bits[cmd.motor_index] = 1'b0;
                end
            end
            OP_START: begin
                load_motor(cmd.motor_index, lim_min);
            end
            OP_THRUST: begin
                if (cmd.thrust_value > 8'(PCT_FULL))
                    rej = 1'b1;
                else
                    thrust_pct = cmd.thrust_value[6:0];
            end
            default: ;
        endcase
        res.compare_one    = cmp_val[0];
        res.compare_two    = cmp_val[1];
        res.compare_three  = cmp_val[2];
        res.compare_four   = cmp_val[3];
        res.armed_mask     = arm_bits;
        res.thrust_percent = thrust_pct;
        res.rejected       = rej;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // track register writes, command and result transfers
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            lim_min    = RST_MIN;
            lim_max    = RST_MAX;
            span       = RST_RANGE;
            period     = RST_PERIOD;
            arm_us     = RST_ARM;
            arm_bits   = '0;
            thrust_pct = '0;
            for (int m = 0; m < 4; m++) begin
                on_us[m]   = '0;
                cmp_val[m] = '0;
            end
            predicted_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MIN:    lim_min = i_cfg_data;
                    REG_MAX:    lim_max = i_cfg_data;
                    REG_RANGE:  span    = i_cfg_data;
                    REG_PERIOD: period  = i_cfg_data;
                    REG_ARM:    arm_us  = i_cfg_data;
                    default: ;
                endcase
            end
            // result first: it can only belong to an earlier command
            if (i_out_valid && !i_out_stall) begin
                if (predicted_q.size() == 0) begin
                    $error("result transfer with no command outstanding: %h", i_out);
                    fails++;
                end else begin
                    want = predicted_q.pop_front();
                    compare_field("compare_one", want.compare_one, i_out.compare_one);
                    compare_field("compare_two", want.compare_two, i_out.compare_two);
                    compare_field("compare_three", want.compare_three,
                                  i_out.compare_three);
                    compare_field("compare_four", want.compare_four, i_out.compare_four);
                    compare_field("armed_mask", 16'(want.armed_mask),
                                  16'(i_out.armed_mask));
                    compare_field("thrust_percent", 16'(want.thrust_percent),
                                  16'(i_out.thrust_percent));
                    compare_field("rejected", 16'(want.rejected), 16'(i_out.rejected));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                mix_command(i_in, want);
                predicted_q.push_back(want);
            end
        end
        o_pending    <= predicted_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> verif/tb_quad_x_motor_mixer_pwm_core.sv
// ----------------------------------------------------------------------------
// tb_quad_x_motor_mixer_pwm_core
// Drives the X-frame mixer with directed and random commands under several
// limit settings, with bursty command traffic and a stalling result side;
// the attached result checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_quad_x_motor_mixer_pwm_core import qxmix_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer
    localparam int ITEMS_PER_PH = 185;
    localparam int NUM_PHASES   = 6;
    localparam int LONG_HOLD    = 600;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    int pending;
    int fail_count;
    int items_sent = 0;
    int reg_writes = 0;
    int op_count [4] = '{0, 0, 0, 0};
    int burst_left = 0;

    quad_x_motor_mixer_pwm_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    qxmix_result_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_in make_cmd(input logic [1:0] op, input int p, input int r,
                                     input int y, input logic [1:0] idx,
                                     input logic arm, input logic [7:0] thr);
        t_in c;
        c.operation    = op;
        c.pitch_offset = 12'(p);
        c.roll_offset  = 12'(r);
        c.yaw_offset   = 12'(y);
        c.motor_index  = idx;
        c.arm_request  = arm;
        c.thrust_value = thr;
        return c;
    endfunction

    // random command: mostly in-window offsets and legal thrust, some full range
    function automatic t_in random_cmd();
        t_in c;
        int  pick;
        pick = $urandom_range(0, 99);
        c.operation = (pick < 35) ? OP_CONTROL :
                      (pick < 60) ? OP_ARM :
                      (pick < 75) ? OP_START : OP_THRUST;
        if ($urandom_range(0, 3) == 0) begin
            c.pitch_offset = 12'($urandom);
            c.roll_offset  = 12'($urandom);
            c.yaw_offset   = 12'($urandom);
        end else begin
            c.pitch_offset = 12'($urandom_range(0, 1200) - 600);
            c.roll_offset  = 12'($urandom_range(0, 1200) - 600);
            c.yaw_offset   = 12'($urandom_range(0, 1200) - 600);
        end
        c.motor_index  = 2'($urandom);
        c.arm_request  = ($urandom_range(0, 2) != 0);
        c.thrust_value = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                         8'($urandom_range(0, 100));
        return c;
    endfunction

    // one command transfer, then maybe a gap ending the current burst
    task automatic push_cmd(input t_in cmd);
        int gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in       = cmd;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        op_count[cmd.operation]++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) :
                                                $urandom_range(0, 3);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                i_in       = t_in'({$urandom, $urandom});
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
                                                       $urandom_range(0, 10);
        end
    endtask

    // stop offering and wait until every result has come back
    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        reg_writes++;
    endtask

    task automatic program_limits(input logic [15:0] mn, input logic [15:0] mx,
                                  input logic [15:0] rg, input logic [15:0] pd,
                                  input logic [15:0] ar);
        write_reg(REG_MIN, mn);
        write_reg(REG_MAX, mx);
        write_reg(REG_RANGE, rg);
        write_reg(REG_PERIOD, pd);
        write_reg(REG_ARM, ar);
    endtask

    // result side: stall pattern per segment, plus one long hold-off
    initial begin
        int  seg_left;
        int  mode;
        int  hold_left;
        int  pat;
        bit  hold_done;
        seg_left    = 0;
        mode        = 0;
        hold_left   = 0;
        pat         = 0;
        hold_done   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && items_sent >= 300) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(20, 300);
                end
                seg_left--;
                pat++;
                case (mode)
                    0:       i_out_stall = 1'b0;
                    1:       i_out_stall = ($urandom_range(0, 3) == 0);
                    2:       i_out_stall = ($urandom_range(0, 3) != 0);
                    default: i_out_stall = ((pat % 5) < 2);
                endcase
            end
        end
    end

    // watchdog: ends the run when transfers stop
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout after %0d quiet cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // stimulus
    initial begin
        t_in directed [$];
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_MIN;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed commands under reset limits
        directed = '{
            make_cmd(OP_CONTROL, 0, 0, 0, 2'd0, 1'b0, 8'd0),
            make_cmd(OP_THRUST, 0, 0, 0, 2'd0, 1'b0, 8'd100),
            make_cmd(OP_THRUST, 0, 0, 0, 2'd0, 1'b0, 8'd101),
            make_cmd(OP_THRUST, 0, 0, 0, 2'd0, 1'b0, 8'd255),
            make_cmd(OP_CONTROL, 2047, 2047, 2047, 2'd0, 1'b0, 8'd0),
            make_cmd(OP_CONTROL, -2048, -2048, -2048, 2'd0, 1'b0, 8'd0),
            make_cmd(OP_CONTROL, 2047, -2048, 0, 2'd0, 1'b0, 8'd0),
            make_cmd(OP_ARM, 0, 0, 0, 2'd0, 1'b1, 8'd0),
            make_cmd(OP_ARM, 0, 0, 0, 2'd1, 1'b1, 8'd0),
            make_cmd(OP_ARM, 0, 0, 0, 2'd2, 1'b1, 8'd0),
            make_cmd(OP_ARM, 0, 0, 0, 2'd3, 1'b1, 8'd0),
            make_cmd(OP_ARM, 0, 0, 0, 2'd1, 1'b1, 8'd0),
            make_cmd(OP_ARM, 0, 0, 0, 2'd0, 1'b0, 8'd0),
            make_cmd(OP_START, 0, 0, 0, 2'd0, 1'b0, 8'd0),
            make_cmd(OP_START, 0, 0, 0, 2'd2, 1'b0, 8'd0),
            make_cmd(OP_THRUST, 0, 0, 0, 2'd0, 1'b0, 8'd0),
            make_cmd(OP_CONTROL, 300, -150, 75, 2'd0, 1'b0, 8'd0),
            make_cmd(OP_ARM, 0, 0, 0, 2'd3, 1'b0, 8'd0),
            make_cmd(OP_THRUST, 0, 0, 0, 2'd0, 1'b0, 8'd50),
            make_cmd(OP_CONTROL, -300, 200, -100, 2'd0, 1'b0, 8'd0),
            make_cmd(OP_CONTROL, 0, 0, 0, 2'd3, 1'b1, 8'd255)
        };
        foreach (directed[k])
            push_cmd(directed[k]);

        // random phases, each under its own limits
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drain();
            case (ph)
                // widest window, unit period: any nonzero on-time saturates its compare
                0: program_limits(16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF);
                // inverted window and zero period
                1: program_limits(16'd3000, 16'd1200, 16'd500, 16'd0, 16'd0);
                2: program_limits(16'd1000, 16'd2000, 16'd1000, 16'd2500, 16'd1100);
                3: program_limits(16'd0, 16'd4095, 16'd0, 16'hFFFF, 16'd4095);
                default: begin
                    logic [15:0] mn;
                    mn = 16'($urandom_range(0, 3000));
                    program_limits(mn, mn + 16'($urandom_range(0, 3000)),
                                   16'($urandom_range(0, 4000)),
                                   16'($urandom_range(1000, 6000)),
                                   16'($urandom_range(0, 6000)));
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PH; k++) begin
                push_cmd(random_cmd());
                if (items_sent == 700)
                    wait_drain();
            end
        end

        wait_drain();
        repeat (180) @(negedge i_clk);

        $display("Ran %0d commands: %0d control, %0d arm/disarm, %0d startup, %0d thrust",
                 items_sent, op_count[OP_CONTROL], op_count[OP_ARM],
                 op_count[OP_START], op_count[OP_THRUST]);
        $display("%0d register writes over %0d limit sets, incl. inverted window, zero period",
                 reg_writes, NUM_PHASES);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
src/qxmix_pkg.sv
src/qxmix_seq.sv
src/qxmix_dp.sv
src/quad_x_motor_mixer_pwm_core.sv
src/qxmix_chk.sv
verif/qxmix_result_checker.sv
verif/tb_quad_x_motor_mixer_pwm_core.sv
